@@ hdl/biquad_lowpass_coef_calc_macros.svh @@
//------------------------------------------------------------------------------
// biquad_lowpass_coef_calc_macros
// Assertion macros shared by the coefficient calculator.
//------------------------------------------------------------------------------
`ifndef BIQUAD_LOWPASS_COEF_CALC_MACROS_SVH
`define BIQUAD_LOWPASS_COEF_CALC_MACROS_SVH

// same-cycle implication
`define BQLP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BQLP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/bqlp_pkg.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_pkg
// Types, constants and Taylor divisor tables for the lowpass coefficient
// calculator.
//------------------------------------------------------------------------------
package bqlp_pkg;

    localparam int          COEF_FRAC_BITS_DEF = 28;
    localparam logic [17:0] FS_RESET  = 18'd48000;
    localparam logic [17:0] FS_MIN    = 18'd8000;
    localparam logic [17:0] FS_MAX    = 18'd192000;
    localparam logic [15:0] FC_MIN    = 16'd20;
    localparam logic [15:0] FC_MAX    = 16'd20000;
    localparam logic [15:0] QC_MIN    = 16'd128;
    localparam logic [15:0] QC_MAX    = 16'd5120;
    localparam logic [31:0] PI_Q30    = 32'd3373259426;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [3:0]  SIN_LAST  = 4'd4;
    localparam logic [3:0]  COS_FIRST = 4'd5;
    localparam logic [3:0]  COS_LAST  = 4'd10;
    localparam int          DIV_STEPS = 31;

    typedef struct packed {
        logic [14:0] fc;
        logic [12:0] qc;
        logic [17:0] fs;
    } bqlp_req_t;

    typedef struct packed {
        logic [31:0] ph;
        logic [12:0] qc;
    } bqlp_phase_t;

    typedef struct packed {
        logic signed [31:0] cosv;
        logic signed [31:0] sinv;
        logic [12:0]        qc;
    } bqlp_trig_t;

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } bqlp_coef_t;

    // sine steps 0..4, cosine steps 5..10
    function automatic logic [7:0] taylor_div(input logic [3:0] idx);
        unique case (idx)
            4'd0:    return 8'd110;
            4'd1:    return 8'd72;
            4'd2:    return 8'd42;
            4'd3:    return 8'd20;
            4'd4:    return 8'd6;
            4'd5:    return 8'd132;
            4'd6:    return 8'd90;
            4'd7:    return 8'd56;
            4'd8:    return 8'd30;
            4'd9:    return 8'd12;
            4'd10:   return 8'd2;
            default: return 8'd2;
        endcase
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] taylor_rcp(input logic [3:0] idx);
        unique case (idx)
            4'd0:    return 32'(64'h1_0000_0000 / 64'd110);
            4'd1:    return 32'(64'h1_0000_0000 / 64'd72);
            4'd2:    return 32'(64'h1_0000_0000 / 64'd42);
            4'd3:    return 32'(64'h1_0000_0000 / 64'd20);
            4'd4:    return 32'(64'h1_0000_0000 / 64'd6);
            4'd5:    return 32'(64'h1_0000_0000 / 64'd132);
            4'd6:    return 32'(64'h1_0000_0000 / 64'd90);
            4'd7:    return 32'(64'h1_0000_0000 / 64'd56);
            4'd8:    return 32'(64'h1_0000_0000 / 64'd30);
            4'd9:    return 32'(64'h1_0000_0000 / 64'd12);
            4'd10:   return 32'(64'h1_0000_0000 / 64'd2);
            default: return 32'(64'h1_0000_0000 / 64'd2);
        endcase
    endfunction

endpackage

@@ hdl/bqlp_if.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_if
// Valid/ready channels for the request and coefficient sides.
//------------------------------------------------------------------------------
interface bqlp_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] cutoff_hz;
    logic [15:0] q_factor;

    modport source (output valid, output cutoff_hz, output q_factor, input ready);
    modport sink   (input valid, input cutoff_hz, input q_factor, output ready);
endinterface

interface bqlp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;

    modport source (output valid, output coef_b0, output coef_b1, output coef_b2,
                    output coef_a1, output coef_a2, input ready);
    modport sink   (input valid, input coef_b0, input coef_b1, input coef_b2,
                    input coef_a1, input coef_a2, output ready);
endinterface

@@ hdl/bqlp_front.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_front
// Sample rate register, input clamping and a two-entry request queue.
//------------------------------------------------------------------------------
module bqlp_front
    import bqlp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [17:0]   cfg_wr_data,
    bqlp_req_if.sink      req,
    output logic          fq_valid,
    input  logic          fq_ready,
    output bqlp_req_t     fq
);

    logic [17:0] fs_reg;
    bqlp_req_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    bqlp_req_t   clamped;

    assign req.ready = (count_reg != 2'd2);
    assign fq_valid  = (count_reg != 2'd0);
    assign fq        = entry_reg[rd_ptr_reg];
    assign push      = req.valid && req.ready;
    assign pop       = fq_valid && fq_ready;

    always_comb
    begin
        priority if (req.cutoff_hz < FC_MIN)
            clamped.fc = 15'(FC_MIN);
        else if (req.cutoff_hz > FC_MAX)
            clamped.fc = 15'(FC_MAX);
        else
            clamped.fc = req.cutoff_hz[14:0];

        priority if (req.q_factor < QC_MIN)
            clamped.qc = 13'(QC_MIN);
        else if (req.q_factor > QC_MAX)
            clamped.qc = 13'(QC_MAX);
        else
            clamped.qc = req.q_factor[12:0];

        priority if (fs_reg < FS_MIN)
            clamped.fs = FS_MIN;
        else if (fs_reg > FS_MAX)
            clamped.fs = FS_MAX;
        else
            clamped.fs = fs_reg;
    end

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg     <= FS_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                fs_reg <= cfg_wr_data;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= clamped;
    end

endmodule

@@ hdl/bqlp_phase.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_phase
// Normalized angle fc/fs in turns, 32 fraction bits, one bit per cycle.
//------------------------------------------------------------------------------
module bqlp_phase
    import bqlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bqlp_req_t   in_req,
    output logic        out_valid,
    input  logic        out_ready,
    output bqlp_phase_t out_ph
);

    typedef enum logic [1:0] {P_IDLE, P_RUN, P_EMIT} state_t;

    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [17:0] rem_reg;
    logic [17:0] fs_reg;
    logic [31:0] quo_reg;
    logic [12:0] qc_reg;
    logic        out_valid_reg;
    bqlp_phase_t out_reg;

    logic [17:0] fc_ext;
    logic [17:0] r1;
    logic [17:0] r0;
    logic [18:0] rem_sh;
    logic        ge;
    logic [17:0] rem_step;

    assign in_ready  = (state_reg == P_IDLE);
    assign out_valid = out_valid_reg;
    assign out_ph    = out_reg;

    always_comb
    begin
        fc_ext   = 18'(in_req.fc);
        r1       = (fc_ext >= in_req.fs) ? fc_ext - in_req.fs : fc_ext;
        r0       = (r1 >= in_req.fs) ? r1 - in_req.fs : r1;
        rem_sh   = {rem_reg, 1'b0};
        ge       = (rem_sh >= {1'b0, fs_reg});
        rem_step = ge ? 18'(rem_sh - {1'b0, fs_reg}) : rem_sh[17:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != P_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE:
                begin
                    if (in_valid)
                    begin
                        rem_reg   <= r0;
                        fs_reg    <= in_req.fs;
                        qc_reg    <= in_req.qc;
                        cnt_reg   <= 5'd0;
                        state_reg <= P_RUN;
                    end
                end
                P_RUN:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= {quo_reg[30:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= P_EMIT;
                end
                P_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.ph    <= quo_reg;
                        out_reg.qc    <= qc_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= P_IDLE;
                    end
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/bqlp_trig.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_trig
// Sine and cosine of the phase: quadrant fold, Horner Taylor series on one
// shared multiplier path, constant division by reciprocal and correction.
//------------------------------------------------------------------------------
module bqlp_trig
    import bqlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bqlp_phase_t in_ph,
    output logic        out_valid,
    input  logic        out_ready,
    output bqlp_trig_t  out_trig
);

    typedef enum logic [2:0] {T_IDLE, T_X, T_X2, T_MUL, T_RCP, T_UPD, T_SIN, T_OUT} state_t;

    state_t      state_reg;
    logic [1:0]  quad_reg;
    logic        rneg_reg;
    logic [29:0] m_reg;
    logic [29:0] x_reg;
    logic [29:0] x2_reg;
    logic [30:0] t_reg;
    logic [29:0] p_reg;
    logic [29:0] q0_reg;
    logic [29:0] s_reg;
    logic [3:0]  step_reg;
    logic [12:0] qc_reg;
    logic        out_valid_reg;
    bqlp_trig_t  out_reg;

    logic [31:0]        ph_rnd;
    logic [1:0]         quad;
    logic [31:0]        dres;
    logic [61:0]        xprod;
    logic [59:0]        x2prod;
    logic [60:0]        mprod;
    logic [61:0]        rprod;
    logic [37:0]        kq;
    logic [37:0]        rr;
    logic [29:0]        qn;
    logic [60:0]        sprod;
    logic signed [31:0] sr;
    logic signed [31:0] cv;

    assign in_ready  = (state_reg == T_IDLE);
    assign out_valid = out_valid_reg;
    assign out_trig  = out_reg;

    always_comb
    begin
        ph_rnd = in_ph.ph + 32'h2000_0000;
        quad   = ph_rnd[31:30];
        dres   = in_ph.ph - {quad, 30'd0};
        xprod  = 62'(m_reg) * 62'(PI_Q30);
        x2prod = 60'(x_reg) * 60'(x_reg);
        mprod  = 61'(x2_reg) * 61'(t_reg);
        rprod  = 62'(p_reg) * 62'(taylor_rcp(step_reg));
        kq     = 38'(q0_reg) * 38'(taylor_div(step_reg));
        rr     = 38'(p_reg) - kq;
        qn     = q0_reg + 30'((rr >= 38'(taylor_div(step_reg))) ? 1 : 0);
        sprod  = 61'(x_reg) * 61'(t_reg);
        sr     = rneg_reg ? -$signed(32'(s_reg)) : $signed(32'(s_reg));
        cv     = $signed(32'(t_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != T_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_valid)
                    begin
                        quad_reg  <= quad;
                        rneg_reg  <= dres[31];
                        m_reg     <= dres[31] ? 30'(-dres) : dres[29:0];
                        qc_reg    <= in_ph.qc;
                        t_reg     <= ONE_Q30;
                        step_reg  <= 4'd0;
                        state_reg <= T_X;
                    end
                end
                T_X:
                begin
                    x_reg     <= 30'((xprod + 62'h4000_0000) >> 31);
                    state_reg <= T_X2;
                end
                T_X2:
                begin
                    x2_reg    <= 30'((x2prod + 60'h2000_0000) >> 30);
                    state_reg <= T_MUL;
                end
                T_MUL:
                begin
                    p_reg     <= 30'(mprod >> 30);
                    state_reg <= T_RCP;
                end
                T_RCP:
                begin
                    q0_reg    <= 30'(rprod >> 32);
                    state_reg <= T_UPD;
                end
                T_UPD:
                begin
                    t_reg <= ONE_Q30 - 31'(qn);
                    priority if (step_reg == SIN_LAST)
                        state_reg <= T_SIN;
                    else if (step_reg == COS_LAST)
                        state_reg <= T_OUT;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= T_MUL;
                    end
                end
                T_SIN:
                begin
                    s_reg     <= 30'(sprod >> 30);
                    t_reg     <= ONE_Q30;
                    step_reg  <= COS_FIRST;
                    state_reg <= T_MUL;
                end
                T_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        unique case (quad_reg)
                            2'd0:
                            begin
                                out_reg.cosv <= cv;
                                out_reg.sinv <= sr;
                            end
                            2'd1:
                            begin
                                out_reg.cosv <= -sr;
                                out_reg.sinv <= cv;
                            end
                            2'd2:
                            begin
                                out_reg.cosv <= -cv;
                                out_reg.sinv <= -sr;
                            end
                            default:
                            begin
                                out_reg.cosv <= sr;
                                out_reg.sinv <= -cv;
                            end
                        endcase
                        out_reg.qc    <= qc_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/bqlp_norm.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// bqlp_norm
// alpha = sin*128/Q by serial division, then four parallel serial dividers
// for the numerators over a0 with rounding and saturation.
//------------------------------------------------------------------------------
module bqlp_norm
    import bqlp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  bqlp_trig_t in_trig,
    output logic       out_valid,
    input  logic       out_ready,
    output bqlp_coef_t out_coef
);

    localparam int NW    = 32 + COEF_FRAC_BITS;
    localparam int LANES = 4;

    typedef enum logic [2:0] {N_IDLE, N_ALPHA, N_SETUP, N_DIV, N_OUT} state_t;

    state_t             state_reg;
    logic [4:0]         cnt_reg;
    logic signed [31:0] cos_reg;
    logic [12:0]        qc_reg;
    logic               aneg_reg;
    logic [12:0]        arem_reg;
    logic [30:0]        abits_reg;
    logic [30:0]        aq_reg;
    logic [31:0]        den_reg;
    logic               neg_reg  [LANES];
    logic               sat_reg  [LANES];
    logic               zero_reg [LANES];
    logic [31:0]        rem_reg  [LANES];
    logic [30:0]        lo_reg   [LANES];
    logic [30:0]        q_reg    [LANES];
    logic               out_valid_reg;
    bqlp_coef_t         out_reg;

    logic [30:0]        amag;
    logic [13:0]        ash;
    logic               age;
    logic signed [32:0] cos_s;
    logic signed [32:0] alpha_s;
    logic signed [32:0] a0_s;
    logic [31:0]        den;
    logic signed [32:0] num_s [LANES];
    logic               lneg  [LANES];
    logic [31:0]        lmag  [LANES];
    logic [NW-1:0]      lnum  [LANES];
    logic               lbig  [LANES];
    logic [32:0]        rsh   [LANES];
    logic               rge   [LANES];
    logic [31:0]        coef  [LANES];

    assign in_ready  = (state_reg == N_IDLE);
    assign out_valid = out_valid_reg;
    assign out_coef  = out_reg;

    always_comb
    begin
        amag    = in_trig.sinv[31] ? 31'(-in_trig.sinv) : in_trig.sinv[30:0];
        ash     = {arem_reg, abits_reg[30]};
        age     = (ash >= {1'b0, qc_reg});
        cos_s   = {cos_reg[31], cos_reg};
        alpha_s = aneg_reg ? -$signed({2'b00, aq_reg}) : $signed({2'b00, aq_reg});
        a0_s    = 33'sh4000_0000 + alpha_s;
        den     = a0_s[31:0];
        num_s[1] = 33'sh4000_0000 - cos_s;
        num_s[0] = num_s[1] >>> 1;
        num_s[2] = -(cos_s <<< 1);
        num_s[3] = 33'sh4000_0000 - alpha_s;
        for (int i = 0; i < LANES; i++)
        begin
            lneg[i] = num_s[i][32];
            lmag[i] = lneg[i] ? 32'(-num_s[i]) : num_s[i][31:0];
            lnum[i] = (NW'(lmag[i]) << COEF_FRAC_BITS) + NW'(den >> 1);
            lbig[i] = (64'(lnum[i]) >= (64'(den) << 31));
            rsh[i]  = {rem_reg[i], lo_reg[i][30]};
            rge[i]  = (rsh[i] >= {1'b0, den_reg});
            priority if (zero_reg[i])
                coef[i] = 32'd0;
            else if (sat_reg[i])
                coef[i] = neg_reg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (neg_reg[i])
                coef[i] = 32'(-{1'b0, q_reg[i]});
            else
                coef[i] = {1'b0, q_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= N_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != N_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (in_valid)
                    begin
                        cos_reg   <= in_trig.cosv;
                        qc_reg    <= in_trig.qc;
                        aneg_reg  <= in_trig.sinv[31];
                        arem_reg  <= 13'(amag[30:24]);
                        abits_reg <= {amag[23:0], 7'd0};
                        cnt_reg   <= 5'd0;
                        state_reg <= N_ALPHA;
                    end
                end
                N_ALPHA:
                begin
                    arem_reg  <= age ? 13'(ash - {1'b0, qc_reg}) : ash[12:0];
                    abits_reg <= {abits_reg[29:0], 1'b0};
                    aq_reg    <= {aq_reg[29:0], age};
                    cnt_reg   <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                        state_reg <= N_SETUP;
                end
                N_SETUP:
                begin
                    den_reg <= den;
                    for (int i = 0; i < LANES; i++)
                    begin
                        neg_reg[i]  <= lneg[i];
                        zero_reg[i] <= (den == 32'd0) && (lmag[i] == 32'd0);
                        sat_reg[i]  <= (den == 32'd0) ? (lmag[i] != 32'd0) : lbig[i];
                        rem_reg[i]  <= 32'(lnum[i] >> 31);
                        lo_reg[i]   <= lnum[i][30:0];
                    end
                    cnt_reg   <= 5'd0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        rem_reg[i] <= rge[i] ? 32'(rsh[i] - {1'b0, den_reg}) : rsh[i][31:0];
                        lo_reg[i]  <= {lo_reg[i][29:0], 1'b0};
                        q_reg[i]   <= {q_reg[i][29:0], rge[i]};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(DIV_STEPS - 1))
                        state_reg <= N_OUT;
                end
                N_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.b0    <= coef[0];
                        out_reg.b1    <= coef[1];
                        out_reg.b2    <= coef[0];
                        out_reg.a1    <= coef[2];
                        out_reg.a2    <= coef[3];
                        out_valid_reg <= 1'b1;
                        state_reg     <= N_IDLE;
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/biquad_lowpass_coef_calc.sv @@
`timescale 1ns / 1ps
`include "biquad_lowpass_coef_calc_macros.svh"
//------------------------------------------------------------------------------
// biquad_lowpass_coef_calc
// Lowpass biquad coefficients b0..a2 over a0 from cutoff, Q and sample rate.
//
// A request transfer (cutoff in Hz, Q in Q8.8) yields one coefficient
// transfer, five signed values with COEF_FRAC_BITS fraction bits. Requests
// enter a two-entry queue, then pass three units that run concurrently on
// successive items: a phase divider, a Taylor sine/cosine unit and a
// normalizer (31-step alpha division followed by four 31-step dividers in
// parallel). The normalizer bounds the sustained rate. The sample rate
// register is sampled when a request is taken.
//------------------------------------------------------------------------------
module biquad_lowpass_coef_calc
    import bqlp_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [17:0] cfg_wr_data,
    bqlp_req_if.sink    req,
    bqlp_rsp_if.source  rsp
);

    logic        fq_valid;
    logic        fq_ready;
    bqlp_req_t   fq;
    logic        ph_valid;
    logic        ph_ready;
    bqlp_phase_t ph;
    logic        tr_valid;
    logic        tr_ready;
    bqlp_trig_t  tr;
    bqlp_coef_t  coef;

    bqlp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .fq_valid    (fq_valid),
        .fq_ready    (fq_ready),
        .fq          (fq)
    );

    bqlp_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_req    (fq),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_ph    (ph)
    );

    bqlp_trig u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_ph     (ph),
        .out_valid (tr_valid),
        .out_ready (tr_ready),
        .out_trig  (tr)
    );

    bqlp_norm #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .in_trig   (tr),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_coef  (coef)
    );

    assign rsp.coef_b0 = coef.b0;
    assign rsp.coef_b1 = coef.b1;
    assign rsp.coef_b2 = coef.b2;
    assign rsp.coef_a1 = coef.a1;
    assign rsp.coef_a2 = coef.a2;

    `BQLP_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, req.valid && req.ready, fq_valid)
    `BQLP_ASSERT_IMPL(a_fs_clamped, clk, rst_n, fq_valid, fq.fs >= FS_MIN && fq.fs <= FS_MAX)
    `BQLP_ASSERT_IMPL(a_b0_eq_b2, clk, rst_n, rsp.valid, rsp.coef_b0 == rsp.coef_b2)

endmodule
